[rtl/zlhw_pkg.sv]
// Shared types and constants for the ZIP local header walker.
package zlhw_pkg;

    localparam logic [31:0] LOCAL_SIG     = 32'h04034b50;
    localparam int          DESC_FLAG_BIT = 3;
    localparam logic [31:0] DEX_TAIL      = 32'h2E646578;
    localparam logic [4:0]  HDR_LAST_IDX  = 5'd29;
    localparam logic [2:0]  BASE_LEN_MAX  = 3'd5;
    localparam logic [7:0]  CHAR_SLASH    = 8'h2F;
    localparam logic [7:0]  CHAR_BSLASH   = 8'h5C;

    localparam logic KIND_ENTRY  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNC_HDR = 2'd1;
    localparam logic [1:0] ST_DATA_DESC = 2'd2;
    localparam logic [1:0] ST_DATA_OOB  = 2'd3;

    typedef enum logic [4:0] {
        PH_HEADER  = 5'b00001,
        PH_NAME    = 5'b00010,
        PH_EXTRA   = 5'b00100,
        PH_DATA    = 5'b01000,
        PH_STOPPED = 5'b10000
    } phase_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] method;
        logic [31:0] crc_value;
        logic [31:0] packed_size;
        logic [31:0] plain_size;
        logic [31:0] data_start;
        logic [1:0]  status;
        logic        last_result;
    } record_t;

    // records produced by one accepted byte, first in rec_a
    typedef struct packed {
        logic [1:0] push_cnt;
        record_t    rec_a;
        record_t    rec_b;
    } walk_out_t;

endpackage

[rtl/zlhw_walker.sv]
// Header walker: per-byte state update and record generation.
module zlhw_walker
    import zlhw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       in_final,
    output walk_out_t  walk_out
);

    phase_t      phase_reg,    phase_next;
    logic [4:0]  idx_reg,      idx_next;
    logic [15:0] flag_reg,     flag_next;
    logic [15:0] method_reg,   method_next;
    logic [31:0] crc_reg,      crc_next;
    logic [31:0] packed_reg,   packed_next;
    logic [31:0] plain_reg,    plain_next;
    logic [15:0] name_len_reg, name_len_next;
    logic [15:0] extra_len_reg, extra_len_next;
    logic [31:0] skip_reg,     skip_next;
    logic [31:0] offset_reg,   offset_next;
    logic [2:0]  base_len_reg, base_len_next;
    logic [31:0] tail_reg,     tail_next;
    logic [1:0]  err_reg,      err_next;

    record_t entry_rec, status_rec;
    logic    entry_vld;

    always_comb begin
        logic        names_done;
        logic        data_done;
        logic [31:0] skip_dec;
        logic [4:0]  k_crc, k_packed, k_plain;
        logic [1:0]  st;

        phase_next     = phase_reg;
        idx_next       = idx_reg;
        flag_next      = flag_reg;
        method_next    = method_reg;
        crc_next       = crc_reg;
        packed_next    = packed_reg;
        plain_next     = plain_reg;
        name_len_next  = name_len_reg;
        extra_len_next = extra_len_reg;
        skip_next      = skip_reg;
        offset_next    = offset_reg + 32'd1;
        base_len_next  = base_len_reg;
        tail_next      = tail_reg;
        err_next       = err_reg;
        names_done     = 1'b0;
        data_done      = 1'b0;
        entry_vld      = 1'b0;
        skip_dec       = skip_reg - 32'd1;
        k_crc          = idx_reg - 5'd14;
        k_packed       = idx_reg - 5'd18;
        k_plain        = idx_reg - 5'd22;
        st             = ST_OK;

        case (phase_reg)
            PH_HEADER: begin
                if (idx_reg == 5'd0) begin
                    flag_next      = '0;
                    method_next    = '0;
                    crc_next       = '0;
                    packed_next    = '0;
                    plain_next     = '0;
                    name_len_next  = '0;
                    extra_len_next = '0;
                    base_len_next  = '0;
                    tail_next      = '0;
                end
                // each stored header byte lands in its own slice exactly once
                if (idx_reg inside {[5'd0:5'd3]}) begin
                    if (in_byte != LOCAL_SIG[{idx_reg[1:0], 3'b000} +: 8]) begin
                        phase_next = PH_STOPPED;
                    end
                end else if (idx_reg inside {[5'd6:5'd7]}) begin
                    flag_next[{idx_reg[0], 3'b000} +: 8] = in_byte;
                end else if (idx_reg inside {[5'd8:5'd9]}) begin
                    method_next[{idx_reg[0], 3'b000} +: 8] = in_byte;
                end else if (idx_reg inside {[5'd14:5'd17]}) begin
                    crc_next[{k_crc[1:0], 3'b000} +: 8] = in_byte;
                end else if (idx_reg inside {[5'd18:5'd21]}) begin
                    packed_next[{k_packed[1:0], 3'b000} +: 8] = in_byte;
                end else if (idx_reg inside {[5'd22:5'd25]}) begin
                    plain_next[{k_plain[1:0], 3'b000} +: 8] = in_byte;
                end else if (idx_reg inside {[5'd26:5'd27]}) begin
                    name_len_next[{idx_reg[0], 3'b000} +: 8] = in_byte;
                end else if (idx_reg inside {[5'd28:5'd29]}) begin
                    extra_len_next[{idx_reg[0], 3'b000} +: 8] = in_byte;
                end
                if (phase_next == PH_HEADER) begin
                    if (idx_reg >= HDR_LAST_IDX) begin
                        idx_next = '0;
                        if (name_len_next != '0) begin
                            skip_next  = {16'd0, name_len_next};
                            phase_next = PH_NAME;
                        end else if (extra_len_next != '0) begin
                            skip_next  = {16'd0, extra_len_next};
                            phase_next = PH_EXTRA;
                        end else begin
                            names_done = 1'b1;
                        end
                    end else begin
                        idx_next = idx_reg + 5'd1;
                    end
                end
            end
            PH_NAME: begin
                if (in_byte == CHAR_SLASH || in_byte == CHAR_BSLASH) begin
                    base_len_next = '0;
                    tail_next     = '0;
                end else begin
                    tail_next = {tail_reg[23:0], in_byte};
                    if (base_len_reg < BASE_LEN_MAX) begin
                        base_len_next = base_len_reg + 3'd1;
                    end
                end
                skip_next = skip_dec;
                if (skip_dec == '0) begin
                    if (extra_len_reg != '0) begin
                        skip_next  = {16'd0, extra_len_reg};
                        phase_next = PH_EXTRA;
                    end else begin
                        names_done = 1'b1;
                    end
                end
            end
            PH_EXTRA: begin
                skip_next = skip_dec;
                if (skip_dec == '0) begin
                    names_done = 1'b1;
                end
            end
            PH_DATA: begin
                skip_next = skip_dec;
                if (skip_dec == '0) begin
                    data_done = 1'b1;
                end
            end
            PH_STOPPED: begin
            end
            default: begin
            end
        endcase

        if (names_done) begin
            if (flag_next[DESC_FLAG_BIT]) begin
                err_next   = ST_DATA_DESC;
                phase_next = PH_STOPPED;
            end else if (packed_next == '0) begin
                data_done = 1'b1;
            end else begin
                skip_next  = packed_next;
                phase_next = PH_DATA;
            end
        end

        if (data_done) begin
            entry_vld  = (base_len_next >= BASE_LEN_MAX) && (tail_next == DEX_TAIL);
            phase_next = PH_HEADER;
            idx_next   = '0;
        end

        entry_rec.kind        = KIND_ENTRY;
        entry_rec.method      = method_next;
        entry_rec.crc_value   = crc_next;
        entry_rec.packed_size = packed_next;
        entry_rec.plain_size  = plain_next;
        entry_rec.data_start  = offset_next - packed_next;
        entry_rec.status      = ST_OK;
        entry_rec.last_result = !in_final;

        if (err_next != ST_OK) begin
            st = err_next;
        end else if (phase_next == PH_NAME || phase_next == PH_EXTRA) begin
            st = ST_TRUNC_HDR;
        end else if (phase_next == PH_DATA) begin
            st = ST_DATA_OOB;
        end
        status_rec             = '0;
        status_rec.kind        = KIND_STATUS;
        status_rec.status      = st;
        status_rec.last_result = 1'b1;

        // final byte: status goes out and the walker starts over
        if (in_final) begin
            phase_next     = PH_HEADER;
            idx_next       = '0;
            flag_next      = '0;
            method_next    = '0;
            crc_next       = '0;
            packed_next    = '0;
            plain_next     = '0;
            name_len_next  = '0;
            extra_len_next = '0;
            skip_next      = '0;
            offset_next    = '0;
            base_len_next  = '0;
            tail_next      = '0;
            err_next       = ST_OK;
        end
    end

    always_comb begin
        walk_out = '0;
        if (in_valid) begin
            if (entry_vld) begin
                walk_out.rec_a    = entry_rec;
                walk_out.rec_b    = status_rec;
                walk_out.push_cnt = in_final ? 2'd2 : 2'd1;
            end else if (in_final) begin
                walk_out.rec_a    = status_rec;
                walk_out.push_cnt = 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            idx_reg       <= '0;
            flag_reg      <= '0;
            method_reg    <= '0;
            crc_reg       <= '0;
            packed_reg    <= '0;
            plain_reg     <= '0;
            name_len_reg  <= '0;
            extra_len_reg <= '0;
            skip_reg      <= '0;
            offset_reg    <= '0;
            base_len_reg  <= '0;
            tail_reg      <= '0;
            err_reg       <= ST_OK;
        end else if (in_valid) begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            flag_reg      <= flag_next;
            method_reg    <= method_next;
            crc_reg       <= crc_next;
            packed_reg    <= packed_next;
            plain_reg     <= plain_next;
            name_len_reg  <= name_len_next;
            extra_len_reg <= extra_len_next;
            skip_reg      <= skip_next;
            offset_reg    <= offset_next;
            base_len_reg  <= base_len_next;
            tail_reg      <= tail_next;
            err_reg       <= err_next;
        end
    end

endmodule

[rtl/zlhw_out_queue.sv]
// Three-slot result queue between the walker and the master port.
module zlhw_out_queue
    import zlhw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  walk_out_t  walk_out,
    input  logic       pop,
    output record_t    head,
    output logic       head_valid,
    output logic       room_for_two,
    output logic [1:0] fill
);

    localparam int DEPTH = 3;

    record_t    slot_reg [DEPTH];
    record_t    slot_next [DEPTH];
    logic [1:0] cnt_reg, cnt_next;

    always_comb begin
        logic [1:0] cnt_pop;

        for (int i = 0; i < DEPTH; i++) begin
            slot_next[i] = slot_reg[i];
        end
        cnt_pop = cnt_reg;
        if (pop && cnt_reg != 2'd0) begin
            slot_next[0] = slot_reg[1];
            slot_next[1] = slot_reg[2];
            cnt_pop      = cnt_reg - 2'd1;
        end
        for (int i = 0; i < DEPTH; i++) begin
            if (walk_out.push_cnt != 2'd0 && cnt_pop == i[1:0]) begin
                slot_next[i] = walk_out.rec_a;
            end
            if (walk_out.push_cnt == 2'd2 && cnt_pop + 2'd1 == i[1:0]) begin
                slot_next[i] = walk_out.rec_b;
            end
        end
        cnt_next = cnt_pop + walk_out.push_cnt;
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            slot_reg[i] <= slot_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    assign head         = slot_reg[0];
    assign head_valid   = (cnt_reg != 2'd0);
    assign room_for_two = (cnt_reg <= 2'd1);
    assign fill         = cnt_reg;

endmodule

[rtl/zip_local_header_walker.sv]
// Top level of the ZIP local header walker.
//
//  channel | direction | tdata                          | tuser | tlast
//  s_      | in        | data_byte                      | -     | final_byte
//  m_      | out       | method..data_start, status     | kind  | last_result
//
// One archive byte is taken per cycle while s_tready is high; its records are
// registered into the result queue and are there in the cycle after the transfer.
// A byte yields at most two records (entry, then status on the final byte).
// s_tready depends only on the queue fill: it is high while two slots are free.
// A stall on m_ holds the queue head; input stalls while two or more records wait.
// Synchronous active-low reset returns the walker to the first header byte.
module zip_local_header_walker
    import zlhw_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata,   // method, crc_value, packed_size, plain_size,
                                    // data_start, status, zero pad
    output logic [0:0]   m_tuser,   // [0] kind
    output logic         m_tlast
);

    walk_out_t  walk_out;
    record_t    head;
    logic       head_valid;
    logic       room_for_two;
    logic [1:0] fill;
    logic       s_xfer;

    assign s_tready = room_for_two;
    assign s_xfer   = s_tvalid && s_tready;

    zlhw_walker u_walker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_xfer),
        .in_byte  (s_tdata),
        .in_final (s_tlast),
        .walk_out (walk_out)
    );

    zlhw_out_queue u_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .walk_out     (walk_out),
        .pop          (m_tvalid && m_tready),
        .head         (head),
        .head_valid   (head_valid),
        .room_for_two (room_for_two),
        .fill         (fill)
    );

    assign m_tvalid = head_valid;
    assign m_tuser  = head.kind;
    assign m_tlast  = head.last_result;
    assign m_tdata  = {6'd0, head.status, head.data_start, head.plain_size,
                       head.packed_size, head.crc_value, head.method};

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill != 2'd3 || !s_tready)
        else $error("input taken with a full result queue");

    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0] == KIND_STATUS) |-> m_tlast)
        else $error("status record not marked last");

    a_final_yields: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
        else $error("final byte produced no record");

endmodule

[bench/zip_local_header_walker_test.sv]
// Testbench for zip_local_header_walker: byte-stream archives checked against a walker model.
module zip_local_header_walker_test
    import zlhw_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_CYCLES  = 120;
    localparam int RANDOM_BYTES = 1120;

    // one short archive: a single local header, optionally cut, then filler bytes
    typedef struct {
        string       name;      // '#' stands for a zero byte
        logic [15:0] flg;
        logic [15:0] mth;
        logic [31:0] crc;
        logic [31:0] csz;
        logic [31:0] usz;
        int          extra_n;
        int          data_n;
        int          keep;      // entry bytes kept, -1 keeps all
        int          tail_n;    // filler after the entry, first one breaks the signature
        bit          typed;
        logic [1:0]  st;
    } archive_case_t;

    archive_case_t dir_cases [15] = '{
        // archive ends inside the signature
        '{"", 16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 0, 0, 1, 0, 1'b1, ST_OK},
        // no signature at all
        '{"", 16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 0, 0, 0, 3, 1'b1, ST_OK},
        '{"classes.dex", 16'h0, 16'h8, 32'hFFFFFFFF, 32'd3, 32'hFFFFFFFF, 2, 3, -1, 0,
          1'b1, ST_OK},
        // zero-size data, judged at the end of the name
        '{"a/b\\lib.dex", 16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 0, 0, -1, 1, 1'b1, ST_OK},
        '{".dex", 16'h0, 16'h8, 32'h1, 32'd1, 32'd1, 0, 1, -1, 0, 1'b1, ST_OK},
        // cut inside the name
        '{"x.dex", 16'h0, 16'h8, 32'h0, 32'd4, 32'd4, 0, 4, 32, 0, 1'b1, ST_TRUNC_HDR},
        // cut inside the extra field
        '{"q.dex", 16'h0, 16'h8, 32'h0, 32'd0, 32'd0, 4, 0, 37, 0, 1'b1, ST_TRUNC_HDR},
        '{"d.dex", 16'h0008, 16'h8, 32'h0, 32'd2, 32'd2, 0, 2, -1, 2, 1'b1, ST_DATA_DESC},
        // descriptor flag, but truncation wins
        '{"d.dex", 16'hFFFF, 16'h8, 32'h0, 32'd2, 32'd2, 0, 2, 32, 0, 1'b1, ST_TRUNC_HDR},
        '{"big.dex", 16'h0, 16'h8, 32'h0, 32'h100, 32'd5, 0, 3, -1, 0, 1'b1, ST_DATA_OOB},
        // entry and status on the same final byte
        '{"e.dex", 16'hFFF7, 16'hFFFF, 32'h12345678, 32'd2, 32'd7, 1, 2, -1, 0, 1'b1, ST_OK},
        '{"#ab.dex", 16'h0, 16'h8, 32'h0, 32'd0, 32'd0, 0, 0, -1, 0, 1'b0, ST_OK},
        '{"dir/", 16'h0, 16'h0, 32'h0, 32'd1, 32'd1, 0, 1, -1, 0, 1'b0, ST_OK},
        '{"", 16'h0, 16'h0, 32'h0, 32'd2, 32'd2, 3, 2, -1, 0, 1'b0, ST_OK},
        // header only, archive ends on its last byte
        '{"", 16'h0, 16'h0, 32'h0, 32'd0, 32'd0, 0, 0, -1, 0, 1'b1, ST_OK}
    };

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [151:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         m_tlast;

    // walker model state
    phase_t      walk_phase;
    logic [4:0]  hdr_pos;
    logic [15:0] flag_acc;
    logic [15:0] meth_acc;
    logic [31:0] crc_acc;
    logic [31:0] csize_acc;
    logic [31:0] usize_acc;
    logic [15:0] name_len;
    logic [15:0] extra_len;
    logic [31:0] bytes_left;
    logic [31:0] next_offset;
    logic [2:0]  base_len;
    logic [31:0] base_tail;
    logic [1:0]  walk_err;

    record_t byte_recs[$];
    record_t expected_recs[$];

    int  mismatches      = 0;
    int  bytes_sent      = 0;
    int  stall_cycles    = 0;
    int  idle_pct        = 31;
    bit  hold_req        = 1'b0;
    bit  hold_done       = 1'b0;

    zip_local_header_walker dut (
        .aclk,
        .aresetn,
        .s_tvalid,
        .s_tready,
        .s_tdata,
        .s_tlast,
        .m_tvalid,
        .m_tready,
        .m_tdata,
        .m_tuser,
        .m_tlast
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
        mismatches++;
    endtask

    function automatic record_t status_rec(input logic [1:0] st);
        record_t r;
        r = '0;
        r.kind        = KIND_STATUS;
        r.status      = st;
        r.last_result = 1'b1;
        return r;
    endfunction

    function automatic void walk_clear();
        walk_phase  = PH_HEADER;
        hdr_pos     = '0;
        flag_acc    = '0;
        meth_acc    = '0;
        crc_acc     = '0;
        csize_acc   = '0;
        usize_acc   = '0;
        name_len    = '0;
        extra_len   = '0;
        bytes_left  = '0;
        next_offset = '0;
        base_len    = '0;
        base_tail   = '0;
        walk_err    = ST_OK;
    endfunction

    function automatic void close_entry();
        record_t r;
        if (base_len >= BASE_LEN_MAX && base_tail == DEX_TAIL) begin
            r = '0;
            r.kind        = KIND_ENTRY;
            r.method      = meth_acc;
            r.crc_value   = crc_acc;
            r.packed_size = csize_acc;
            r.plain_size  = usize_acc;
            r.data_start  = next_offset - csize_acc;
            r.status      = ST_OK;
            byte_recs.insert(byte_recs.size(), r);
        end
        walk_phase = PH_HEADER;
        hdr_pos    = '0;
    endfunction

    function automatic void names_done();
        if (flag_acc[DESC_FLAG_BIT]) begin
            walk_err   = ST_DATA_DESC;
            walk_phase = PH_STOPPED;
        end else if (csize_acc == 0) begin
            close_entry();
        end else begin
            bytes_left = csize_acc;
            walk_phase = PH_DATA;
        end
    endfunction

    // records one archive byte produces, left in byte_recs
    function automatic void walk_byte(input logic [7:0] b, input logic fin);
        int         i;
        logic [1:0] st;
        byte_recs.delete();
        next_offset = next_offset + 32'd1;
        case (walk_phase)
            PH_HEADER: begin
                i = int'(hdr_pos);
                if (i == 0) begin
                    flag_acc  = '0;
                    meth_acc  = '0;
                    crc_acc   = '0;
                    csize_acc = '0;
                    usize_acc = '0;
                    name_len  = '0;
                    extra_len = '0;
                    base_len  = '0;
                    base_tail = '0;
                end
                if (i < 4) begin
                    if (b != LOCAL_SIG[8*i +: 8]) walk_phase = PH_STOPPED;
                end else if (i == 6 || i == 7) begin
                    flag_acc[8*(i-6) +: 8] = b;
                end else if (i == 8 || i == 9) begin
                    meth_acc[8*(i-8) +: 8] = b;
                end else if (i >= 14 && i <= 17) begin
                    crc_acc[8*(i-14) +: 8] = b;
                end else if (i >= 18 && i <= 21) begin
                    csize_acc[8*(i-18) +: 8] = b;
                end else if (i >= 22 && i <= 25) begin
                    usize_acc[8*(i-22) +: 8] = b;
                end else if (i == 26 || i == 27) begin
                    name_len[8*(i-26) +: 8] = b;
                end else if (i == 28 || i == 29) begin
                    extra_len[8*(i-28) +: 8] = b;
                end
                if (walk_phase == PH_HEADER) begin
                    if (i == HDR_LAST_IDX) begin
                        hdr_pos = '0;
                        if (name_len != 0) begin
                            bytes_left = 32'(name_len);
                            walk_phase = PH_NAME;
                        end else if (extra_len != 0) begin
                            bytes_left = 32'(extra_len);
                            walk_phase = PH_EXTRA;
                        end else begin
                            names_done();
                        end
                    end else begin
                        hdr_pos = hdr_pos + 5'd1;
                    end
                end
            end
            PH_NAME: begin
                if (b == CHAR_SLASH || b == CHAR_BSLASH) begin
                    base_len  = '0;
                    base_tail = '0;
                end else begin
                    base_tail = {base_tail[23:0], b};
                    if (base_len < BASE_LEN_MAX) base_len = base_len + 3'd1;
                end
                bytes_left = bytes_left - 32'd1;
                if (bytes_left == 0) begin
                    if (extra_len != 0) begin
                        bytes_left = 32'(extra_len);
                        walk_phase = PH_EXTRA;
                    end else begin
                        names_done();
                    end
                end
            end
            PH_EXTRA: begin
                bytes_left = bytes_left - 32'd1;
                if (bytes_left == 0) names_done();
            end
            PH_DATA: begin
                bytes_left = bytes_left - 32'd1;
                if (bytes_left == 0) close_entry();
            end
            default: ;
        endcase
        if (fin) begin
            if (walk_err != ST_OK) st = walk_err;
            else if (walk_phase == PH_NAME || walk_phase == PH_EXTRA) st = ST_TRUNC_HDR;
            else if (walk_phase == PH_DATA) st = ST_DATA_OOB;
            else st = ST_OK;
            byte_recs.insert(byte_recs.size(), status_rec(st));
            walk_clear();
        end
        if (byte_recs.size() != 0) begin
            byte_recs[byte_recs.size() - 1].last_result = 1'b1;
        end
    endfunction

    function automatic void put_le(ref logic [7:0] q[$], input logic [31:0] v, input int n);
        int j;
        for (j = 0; j < n; j++) q.insert(q.size(), v[8*j +: 8]);
    endfunction

    function automatic void add_entry(ref logic [7:0] q[$], input logic [7:0] nm[$],
                                      input logic [15:0] flg, input logic [15:0] mth,
                                      input logic [31:0] crc, input logic [31:0] csz,
                                      input logic [31:0] usz, input int extra_n,
                                      input int data_n);
        put_le(q, LOCAL_SIG, 4);
        put_le(q, $urandom, 2);          // version needed
        put_le(q, 32'(flg), 2);
        put_le(q, 32'(mth), 2);
        put_le(q, $urandom, 4);          // mod time and date
        put_le(q, crc, 4);
        put_le(q, csz, 4);
        put_le(q, usz, 4);
        put_le(q, nm.size(), 2);
        put_le(q, extra_n, 2);
        foreach (nm[k]) q.insert(q.size(), nm[k]);
        repeat (extra_n) q.insert(q.size(), 8'($urandom_range(0, 255)));
        repeat (data_n) q.insert(q.size(), 8'($urandom_range(0, 255)));
    endfunction

    // entered and left at a falling edge; final flag rides on the last byte
    task automatic send_archive(input logic [7:0] q[$], input bit typed,
                                input logic [1:0] st);
        logic fin;
        foreach (q[k]) begin
            fin = (k == q.size() - 1);
            while ($urandom_range(0, 99) < idle_pct) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= q[k];
            s_tlast  <= fin;
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            walk_byte(q[k], fin);
            if (typed && fin) begin
                byte_recs[byte_recs.size() - 1] = status_rec(st);
            end
            foreach (byte_recs[r]) expected_recs.insert(expected_recs.size(), byte_recs[r]);
            bytes_sent++;
            if (bytes_sent == 300) hold_req = 1'b1;
            idle_pct = (bytes_sent >= 500 && bytes_sent < 800) ? 0 : 31;
            @(negedge aclk);
        end
    endtask

    initial begin : stimulus
        logic [7:0]  q[$];
        logic [7:0]  nm[$];
        string       nstr;
        int          j;
        int          dir_bytes;
        int          n_ent;
        int          last_start;
        int          ending;
        int          pick;
        logic [15:0] flg;
        logic [15:0] mth;
        logic [31:0] csz;
        int          data_n;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        walk_clear();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_cases[c]) begin
            q.delete();
            nm.delete();
            nstr = dir_cases[c].name;
            for (j = 0; j < nstr.len(); j++)
                nm.insert(nm.size(), nstr[j] == 8'h23 ? 8'h00 : nstr[j]);
            add_entry(q, nm, dir_cases[c].flg, dir_cases[c].mth, dir_cases[c].crc,
                      dir_cases[c].csz, dir_cases[c].usz, dir_cases[c].extra_n,
                      dir_cases[c].data_n);
            if (dir_cases[c].keep == 0) q.delete();
            else if (dir_cases[c].keep > 0) q = q[0:dir_cases[c].keep-1];
            for (j = 0; j < dir_cases[c].tail_n; j++)
                q.insert(q.size(), j == 0 ? 8'hFF : 8'h00);
            send_archive(q, dir_cases[c].typed, dir_cases[c].st);
        end
        dir_bytes = bytes_sent;

        // mostly well-formed archives, some cut, some followed by junk
        while (bytes_sent < dir_bytes + RANDOM_BYTES) begin
            q.delete();
            last_start = 0;
            n_ent = $urandom_range(0, 3);
            for (int e = 0; e < n_ent; e++) begin
                nm.delete();
                pick = $urandom_range(0, 99);
                if (pick >= 5) begin
                    repeat ($urandom_range(0, 2)) begin
                        repeat ($urandom_range(1, 3))
                            nm.insert(nm.size(), 8'(8'h61 + $urandom_range(0, 25)));
                        nm.insert(nm.size(), $urandom_range(0, 1) ? CHAR_SLASH : CHAR_BSLASH);
                    end
                    if (pick < 55) begin
                        repeat ($urandom_range(0, 4))
                            nm.insert(nm.size(), 8'($urandom_range(0, 255)));
                        for (j = 3; j >= 0; j--) nm.insert(nm.size(), DEX_TAIL[8*j +: 8]);
                    end else if (pick < 70) begin
                        // almost a dex name
                        repeat ($urandom_range(1, 3))
                            nm.insert(nm.size(), 8'(8'h61 + $urandom_range(0, 25)));
                        for (j = 3; j >= 1; j--) nm.insert(nm.size(), DEX_TAIL[8*j +: 8]);
                        nm.insert(nm.size(), 8'($urandom_range(0, 255)));
                    end else begin
                        repeat ($urandom_range(1, 8))
                            nm.insert(nm.size(), 8'($urandom_range(0, 255)));
                    end
                end
                flg = 16'($urandom_range(0, 65535));
                if ($urandom_range(0, 99) >= 5) flg[DESC_FLAG_BIT] = 1'b0;
                pick = $urandom_range(0, 3);
                mth = (pick < 2) ? 16'h8 : (pick == 2) ? 16'h0 : 16'($urandom_range(0, 65535));
                if (e == n_ent - 1 && $urandom_range(0, 99) < 8) begin
                    csz    = $urandom | 32'h100;
                    data_n = $urandom_range(0, 12);
                end else begin
                    csz    = ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom_range(1, 12));
                    data_n = csz;
                end
                last_start = q.size();
                add_entry(q, nm, flg, mth, $urandom, csz, $urandom,
                          ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 6), data_n);
            end
            ending = $urandom_range(0, 9);
            if (ending == 5 || ending == 6) begin
                if (n_ent > 0)
                    repeat ($urandom_range(1, q.size() - last_start - 1)) void'(q.pop_back());
            end else if (ending == 7 || ending == 8) begin
                repeat ($urandom_range(1, 40)) q.insert(q.size(), 8'($urandom_range(0, 255)));
            end else if (ending == 9) begin
                // a signature, possibly partial, then random bytes
                put_le(q, LOCAL_SIG, $urandom_range(1, 4));
                repeat ($urandom_range(0, 40)) q.insert(q.size(), 8'($urandom_range(0, 255)));
            end
            if (q.size() == 0) q.insert(q.size(), 8'($urandom_range(0, 255)));
            send_archive(q, 1'b0, ST_OK);
        end
        s_tvalid <= 1'b0;

        while (expected_recs.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // result side: random back-pressure plus one long hold-off
    initial begin : drain
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_tready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    always @(posedge aclk) begin : check_records
        record_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_recs.size() == 0) begin
                note_mismatch("record with nothing pending", m_tdata[31:0], 32'h0);
            end else begin
                want = expected_recs.pop_front();
                if (m_tuser[0] !== want.kind)
                    note_mismatch("kind", 32'(m_tuser[0]), 32'(want.kind));
                if (m_tdata[15:0] !== want.method)
                    note_mismatch("method", 32'(m_tdata[15:0]), 32'(want.method));
                if (m_tdata[47:16] !== want.crc_value)
                    note_mismatch("crc_value", m_tdata[47:16], want.crc_value);
                if (m_tdata[79:48] !== want.packed_size)
                    note_mismatch("packed_size", m_tdata[79:48], want.packed_size);
                if (m_tdata[111:80] !== want.plain_size)
                    note_mismatch("plain_size", m_tdata[111:80], want.plain_size);
                if (m_tdata[143:112] !== want.data_start)
                    note_mismatch("data_start", m_tdata[143:112], want.data_start);
                if (m_tdata[145:144] !== want.status)
                    note_mismatch("status", 32'(m_tdata[145:144]), 32'(want.status));
                if (m_tlast !== want.last_result)
                    note_mismatch("last_result", 32'(m_tlast), 32'(want.last_result));
            end
        end
    end

    // ends the run when neither side moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
